FILE: rtl/core/jets_pkg.sv
// shared types, constants and helpers for the julia escape-time core
package jets_pkg;

  localparam int unsigned FracBits = 28;
  localparam int unsigned Width    = 1024;
  localparam int unsigned Height   = 1024;
  localparam int unsigned PixW     = 10;
  localparam int unsigned StepW    = 31;
  localparam int unsigned PlaneW   = 32;
  localparam int unsigned CountW   = 16;
  localparam int unsigned ProdW    = 2 * PlaneW;
  localparam int unsigned StartW   = PixW + StepW;
  localparam int unsigned WideW    = 44;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 32;

  localparam logic [PixW-1:0] MaxCol = PixW'(Width - 1);
  localparam logic [PixW-1:0] MaxRow = PixW'(Height - 1);
  localparam logic signed [WideW-1:0] EscapeBound = WideW'(64'sd4 <<< FracBits);

  typedef enum logic [1:0] {
    VarJulia   = 2'd0,
    VarConj    = 2'd1,
    VarBothAbs = 2'd2,
    VarRealAbs = 2'd3
  } variant_e;

  typedef enum logic [CfgIdxW-1:0] {
    RegVariant   = 3'd0,
    RegPixelStep = 3'd1,
    RegOriginRe  = 3'd2,
    RegOriginIm  = 3'd3,
    RegConstRe   = 3'd4,
    RegConstIm   = 3'd5,
    RegIterLimit = 3'd6
  } cfg_reg_e;

  typedef enum logic [1:0] {
    StIdle,
    StMul,
    StCheck
  } ctrl_state_e;

  typedef struct packed {
    logic [PixW-1:0] pixel_x;
    logic [PixW-1:0] pixel_y;
  } in_t;

  typedef struct packed {
    logic [PixW-1:0]   out_x;
    logic [PixW-1:0]   out_y;
    logic [CountW-1:0] iteration_count;
    logic              escaped;
  } out_t;

  typedef struct packed {
    variant_e                  variant;
    logic [StepW-1:0]          pixel_step;
    logic signed [PlaneW-1:0]  origin_real;
    logic signed [PlaneW-1:0]  origin_imag;
    logic signed [PlaneW-1:0]  const_real;
    logic signed [PlaneW-1:0]  const_imag;
    logic [CountW-1:0]         iteration_limit;
  } cfg_t;

  typedef struct packed {
    logic load;
    logic mul;
    logic step;
    logic emit;
  } dp_cmd_t;

  typedef struct packed {
    logic outside;
    logic at_limit;
    logic out_free;
  } dp_stat_t;

  function automatic logic signed [PlaneW-1:0] sat32(input logic signed [WideW-1:0] v);
    logic signed [WideW-1:0] hi;
    logic signed [WideW-1:0] lo;
    hi = WideW'({1'b0, {(PlaneW-1){1'b1}}});
    lo = -hi - WideW'(1);
    if (v > hi) begin
      return PlaneW'(hi);
    end else if (v < lo) begin
      return PlaneW'(lo);
    end
    return PlaneW'(v);
  endfunction

  function automatic logic signed [WideW-1:0] abs_w(input logic signed [WideW-1:0] v);
    return (v < 0) ? -v : v;
  endfunction

endpackage

FILE: rtl/core/jets_ctrl.sv
// controller: sequences load, multiply and update steps of one pixel
module jets_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  jets_pkg::dp_stat_t stat_i,
  output jets_pkg::dp_cmd_t  cmd_o
);

  jets_pkg::ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= jets_pkg::StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    case (state_q)
      jets_pkg::StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = jets_pkg::StMul;
        end
      end
      jets_pkg::StMul: begin
        cmd_o.mul = 1'b1;
        state_d   = jets_pkg::StCheck;
      end
      jets_pkg::StCheck: begin
        if (stat_i.outside || stat_i.at_limit) begin
          // hold here until the output register can take the word
          if (stat_i.out_free) begin
            cmd_o.emit = 1'b1;
            state_d    = jets_pkg::StIdle;
          end
        end else begin
          cmd_o.step = 1'b1;
          state_d    = jets_pkg::StMul;
        end
      end
      default: begin
        state_d = jets_pkg::StIdle;
      end
    endcase
  end

endmodule

FILE: rtl/core/jets_dp.sv
// datapath: start point, three shared products and the z update
module jets_dp (
  input  logic              clk_i,
  input  jets_pkg::cfg_t    cfg_i,
  input  jets_pkg::in_t     in_i,
  input  jets_pkg::dp_cmd_t cmd_i,
  output logic              outside_o,
  output logic              at_limit_o,
  output jets_pkg::out_t    res_o
);

  logic [jets_pkg::PixW-1:0]          px_q, py_q;
  logic signed [jets_pkg::PlaneW-1:0] zr_q, zi_q;
  logic signed [jets_pkg::ProdW-1:0]  prr_q, pii_q, pri_q;
  logic [jets_pkg::CountW-1:0]        count_q;

  logic [jets_pkg::PixW-1:0]          cx, cy;
  logic [jets_pkg::StartW-1:0]        offs_r, offs_i;
  logic signed [jets_pkg::WideW-1:0]  start_r, start_i;
  logic signed [jets_pkg::WideW-1:0]  sqr, sqi, cross2, diff, nr, ni;
  logic signed [jets_pkg::WideW-1:0]  cr, ci;

  // out-of-frame pixels land on the last column or row
  assign cx = (in_i.pixel_x > jets_pkg::MaxCol) ? jets_pkg::MaxCol : in_i.pixel_x;
  assign cy = (in_i.pixel_y > jets_pkg::MaxRow) ? jets_pkg::MaxRow : in_i.pixel_y;

  assign offs_r  = jets_pkg::StartW'(cx) * jets_pkg::StartW'(cfg_i.pixel_step);
  assign offs_i  = jets_pkg::StartW'(cy) * jets_pkg::StartW'(cfg_i.pixel_step);
  assign start_r = jets_pkg::WideW'(offs_r) + jets_pkg::WideW'(cfg_i.origin_real);
  assign start_i = jets_pkg::WideW'(offs_i) + jets_pkg::WideW'(cfg_i.origin_imag);

  // products are reduced with floor rounding
  assign sqr    = jets_pkg::WideW'(prr_q >>> jets_pkg::FracBits);
  assign sqi    = jets_pkg::WideW'(pii_q >>> jets_pkg::FracBits);
  assign cross2 = jets_pkg::WideW'(pri_q >>> (jets_pkg::FracBits - 1));
  assign diff   = sqr - sqi;
  assign cr     = jets_pkg::WideW'(cfg_i.const_real);
  assign ci     = jets_pkg::WideW'(cfg_i.const_imag);

  always_comb begin
    case (cfg_i.variant)
      jets_pkg::VarConj: begin
        nr = diff + cr;
        ni = ci - cross2;
      end
      jets_pkg::VarBothAbs: begin
        nr = jets_pkg::abs_w(diff + cr);
        ni = jets_pkg::abs_w(cross2 + ci);
      end
      jets_pkg::VarRealAbs: begin
        nr = jets_pkg::abs_w(diff) + cr;
        ni = cross2 + ci;
      end
      default: begin
        nr = diff + cr;
        ni = cross2 + ci;
      end
    endcase
  end

  assign outside_o  = (sqr + sqi) >= jets_pkg::EscapeBound;
  assign at_limit_o = count_q >= cfg_i.iteration_limit;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      px_q    <= in_i.pixel_x;
      py_q    <= in_i.pixel_y;
      zr_q    <= jets_pkg::sat32(start_r);
      zi_q    <= jets_pkg::sat32(start_i);
      count_q <= '0;
    end else if (cmd_i.step) begin
      zr_q    <= jets_pkg::sat32(nr);
      zi_q    <= jets_pkg::sat32(ni);
      count_q <= count_q + jets_pkg::CountW'(1);
    end
    if (cmd_i.mul) begin
      prr_q <= zr_q * zr_q;
      pii_q <= zi_q * zi_q;
      pri_q <= zr_q * zi_q;
    end
  end

  assign res_o.out_x           = px_q;
  assign res_o.out_y           = py_q;
  assign res_o.iteration_count = count_q;
  assign res_o.escaped         = outside_o;

endmodule

FILE: rtl/core/julia_escape_time_variants_core.sv
// Julia escape-time core: one pixel in, its iteration count out. A pixel is
// taken when the core is idle; the start point is formed in the accept cycle,
// then each iteration has a multiply step for the three 32x32 products
// (zr*zr, zi*zi, zr*zi) and a check step for the escape test and the z update.
// The result is emitted from the check step once the output register is free,
// and the next pixel can be taken from the cycle in which the result turns
// valid. The result sits in an output register, so a new pixel is accepted
// while the previous word waits. Configuration writes take effect at once and
// should only be made while no pixel is in flight.
module julia_escape_time_variants_core (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [jets_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [jets_pkg::CfgDataW-1:0]   cfg_wdata_i,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  jets_pkg::in_t                   in_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output jets_pkg::out_t                  out_o
);

  jets_pkg::cfg_t     cfg_q;
  jets_pkg::dp_cmd_t  cmd;
  jets_pkg::dp_stat_t stat;
  jets_pkg::out_t     res, out_q;
  logic               out_valid_q;
  logic               outside, at_limit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.variant         <= jets_pkg::VarJulia;
      cfg_q.pixel_step      <= 31'd1048576;
      cfg_q.origin_real     <= 32'shE000_0000;
      cfg_q.origin_imag     <= 32'shE000_0000;
      cfg_q.const_real      <= 32'shF400_0000;
      cfg_q.const_imag      <= 32'sh0000_0000;
      cfg_q.iteration_limit <= 16'd50;
    end else if (cfg_we_i) begin
      case (jets_pkg::cfg_reg_e'(cfg_idx_i))
        jets_pkg::RegVariant:   cfg_q.variant     <= jets_pkg::variant_e'(cfg_wdata_i[1:0]);
        jets_pkg::RegPixelStep: cfg_q.pixel_step  <= cfg_wdata_i[jets_pkg::StepW-1:0];
        jets_pkg::RegOriginRe:  cfg_q.origin_real <= $signed(cfg_wdata_i);
        jets_pkg::RegOriginIm:  cfg_q.origin_imag <= $signed(cfg_wdata_i);
        jets_pkg::RegConstRe:   cfg_q.const_real  <= $signed(cfg_wdata_i);
        jets_pkg::RegConstIm:   cfg_q.const_imag  <= $signed(cfg_wdata_i);
        jets_pkg::RegIterLimit: begin
          cfg_q.iteration_limit <= cfg_wdata_i[jets_pkg::CountW-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  assign stat.outside  = outside;
  assign stat.at_limit = at_limit;
  assign stat.out_free = !out_valid_q || out_ready_i;

  jets_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  jets_dp u_dp (
    .clk_i      (clk_i),
    .cfg_i      (cfg_q),
    .in_i       (in_i),
    .cmd_i      (cmd),
    .outside_o  (outside),
    .at_limit_o (at_limit),
    .res_o      (res)
  );

  // output word register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd.emit) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

endmodule

FILE: rtl/core/jets_checker.sv
// port-level checks for the julia escape-time core, bound to the top level
module jets_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           in_valid_i,
  input logic           in_ready_o,
  input logic           out_valid_o,
  input logic           out_ready_i,
  input jets_pkg::out_t out_o
);

  // a waiting word holds until taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_o))
    else $error("output word changed or dropped while stalled");

  // one pixel at a time: no accept in the cycle after an accept
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("second pixel accepted while busy");

  // a result needs at least a multiply step and a check step
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && !out_valid_o |=> !out_valid_o)
    else $error("result appeared right after accept");

  // the echoed pixel holds while the word waits
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(out_o.out_x) && $stable(out_o.out_y))
    else $error("echoed pixel changed while stalled");

endmodule

bind julia_escape_time_variants_core jets_checker u_jets_checker (.*);
